// File: hw/rtl/tse_pkg.sv
package tse_pkg;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int POS_W  = 16;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_NAME_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_EXTENSIONS  = 1'b1;

    localparam logic [BYTE_W-1:0] MAX_NAME_LENGTH_RST = 8'd128;
    localparam logic [BYTE_W-1:0] MAX_EXTENSIONS_RST  = 8'd16;

    // TLS framing constants
    localparam logic [BYTE_W-1:0] CT_HANDSHAKE     = 8'd22;
    localparam logic [BYTE_W-1:0] HS_CLIENT_HELLO  = 8'd1;
    localparam logic [BYTE_W-1:0] NUL_BYTE         = 8'h00;
    localparam logic [POS_W-1:0]  POS_CONTENT_TYPE = 16'd0;
    localparam logic [POS_W-1:0]  POS_HS_TYPE      = 16'd5;
    localparam logic [POS_W-1:0]  POS_SID_LEN      = 16'd43;
    localparam logic [POS_W-1:0]  POS_MAX          = 16'hFFFF;
    // ext len, list len, name type, name len
    localparam logic [POS_W-1:0]  SNI_HDR_SKIP     = 16'd7;
    localparam logic [POS_W-1:0]  SNI_LEN_HI       = 16'd2;
    localparam logic [POS_W-1:0]  SNI_LEN_LO       = 16'd1;
    localparam logic [POS_W-1:0]  EXT_TYPE_SNI     = 16'd0;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    // One queue entry: everything one payload byte produces
    typedef struct packed {
        logic              has_char;
        logic [BYTE_W-1:0] name_char;
        logic [BYTE_W-1:0] name_length;
        logic              has_sum;
        logic              found;
    } tse_entry_t;

    typedef struct packed {
        logic       push;
        tse_entry_t entry;
    } tse_push_t;

endpackage

// File: hw/rtl/tse_parser.sv
module tse_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    // accepted payload word
    input  logic                          in_accept,
    input  logic [tse_pkg::BYTE_W-1:0]    in_byte,
    input  logic                          in_last,
    // configuration writes
    input  logic                          cfg_write,
    input  logic [tse_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tse_pkg::BYTE_W-1:0]    cfg_data,
    // word held in the input or result register
    output logic                          in_flight,
    output tse_pkg::tse_push_t            result
);
    import tse_pkg::*;

    typedef enum logic [3:0] {
        PH_HEAD    = 4'd0,
        PH_SKIPSID = 4'd1,
        PH_CSHI    = 4'd2,
        PH_CSLO    = 4'd3,
        PH_SKIPCS  = 4'd4,
        PH_CMLEN   = 4'd5,
        PH_SKIPCM  = 4'd6,
        PH_ETHI    = 4'd7,
        PH_ETLO    = 4'd8,
        PH_ELHI    = 4'd9,
        PH_ELLO    = 4'd10,
        PH_SKIPEXT = 4'd11,
        PH_SNIHDR  = 4'd12,
        PH_NAME    = 4'd13,
        PH_DONE    = 4'd14,
        PH_FAIL    = 4'd15
    } phase_t;

    // Input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;

    // Config registers
    logic [BYTE_W-1:0] max_name_reg;
    logic [BYTE_W-1:0] max_ext_reg;

    // Parse state
    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  skip_reg, skip_next;
    logic [BYTE_W-1:0] hold_reg, hold_next;
    logic [BYTE_W-1:0] ext_reg, ext_next;
    logic [BYTE_W-1:0] rem_reg, rem_next;
    logic [BYTE_W-1:0] chars_reg, chars_next;
    logic              complete_reg, complete_next;

    tse_push_t         result_reg, result_next;

    logic [POS_W-1:0]  word;
    logic [POS_W-1:0]  skip_dec;
    logic [BYTE_W-1:0] ext_inc;
    logic              ext_limit;
    logic [BYTE_W-1:0] rem_dec;
    logic              emit;

    assign word      = {hold_reg, byte_reg};
    assign skip_dec  = skip_reg - POS_W'(1);
    assign ext_inc   = ext_reg + BYTE_W'(1);
    assign ext_limit = (ext_inc >= max_ext_reg);
    assign rem_dec   = rem_reg - BYTE_W'(1);

    // Per-byte parse step on the registered word
    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        skip_next     = skip_reg;
        hold_next     = hold_reg;
        ext_next      = ext_reg;
        rem_next      = rem_reg;
        chars_next    = chars_reg;
        complete_next = complete_reg;
        emit          = 1'b0;

        if (in_valid_reg)
        begin
            case (phase_reg)
                PH_HEAD:
                begin
                    if (pos_reg == POS_CONTENT_TYPE && byte_reg != CT_HANDSHAKE)
                    begin
                        phase_next = PH_FAIL;
                    end
                    else if (pos_reg == POS_HS_TYPE && byte_reg != HS_CLIENT_HELLO)
                    begin
                        phase_next = PH_FAIL;
                    end
                    else if (pos_reg == POS_SID_LEN)
                    begin
                        skip_next  = {8'd0, byte_reg};
                        phase_next = (byte_reg == NUL_BYTE) ? PH_CSHI : PH_SKIPSID;
                    end
                    if (pos_reg != POS_MAX)
                    begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
                PH_SKIPSID, PH_SKIPCS, PH_SKIPCM, PH_SKIPEXT:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        case (phase_reg)
                            PH_SKIPSID: phase_next = PH_CSHI;
                            PH_SKIPCS:  phase_next = PH_CMLEN;
                            PH_SKIPCM:  phase_next = PH_ETHI;
                            default:
                            begin
                                ext_next   = ext_inc;
                                phase_next = ext_limit ? PH_FAIL : PH_ETHI;
                            end
                        endcase
                    end
                end
                PH_CSHI:
                begin
                    hold_next  = byte_reg;
                    phase_next = PH_CSLO;
                end
                PH_ETHI:
                begin
                    hold_next  = byte_reg;
                    phase_next = PH_ETLO;
                end
                PH_ELHI:
                begin
                    hold_next  = byte_reg;
                    phase_next = PH_ELLO;
                end
                PH_CSLO:
                begin
                    skip_next  = word;
                    phase_next = (word == '0) ? PH_CMLEN : PH_SKIPCS;
                end
                PH_CMLEN:
                begin
                    // compression methods plus the two-byte extensions length
                    skip_next  = {8'd0, byte_reg} + POS_W'(2);
                    phase_next = PH_SKIPCM;
                end
                PH_ETLO:
                begin
                    if (word == EXT_TYPE_SNI)
                    begin
                        skip_next  = SNI_HDR_SKIP;
                        phase_next = PH_SNIHDR;
                    end
                    else
                    begin
                        phase_next = PH_ELHI;
                    end
                end
                PH_ELLO:
                begin
                    skip_next = word;
                    if (word == '0)
                    begin
                        ext_next   = ext_inc;
                        phase_next = ext_limit ? PH_FAIL : PH_ETHI;
                    end
                    else
                    begin
                        phase_next = PH_SKIPEXT;
                    end
                end
                PH_SNIHDR:
                begin
                    if (skip_reg == SNI_LEN_HI)
                    begin
                        hold_next = byte_reg;
                    end
                    else if (skip_reg == SNI_LEN_LO)
                    begin
                        if (word == '0 || word > {8'd0, max_name_reg})
                        begin
                            phase_next = PH_FAIL;
                        end
                        else
                        begin
                            rem_next   = word[BYTE_W-1:0];
                            phase_next = PH_NAME;
                        end
                    end
                    skip_next = skip_dec;
                end
                PH_NAME:
                begin
                    if (byte_reg == NUL_BYTE)
                    begin
                        // terminator ends the name; an empty name fails
                        if (chars_reg != '0)
                        begin
                            complete_next = 1'b1;
                            phase_next    = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_FAIL;
                        end
                    end
                    else
                    begin
                        emit       = 1'b1;
                        chars_next = chars_reg + BYTE_W'(1);
                        rem_next   = rem_dec;
                        if (rem_dec == '0)
                        begin
                            complete_next = 1'b1;
                            phase_next    = PH_DONE;
                        end
                    end
                end
                default:
                begin
                    // done or failed: wait for the last byte
                end
            endcase
        end

        result_next.push              = in_valid_reg && (emit || last_reg);
        result_next.entry.has_char    = emit;
        result_next.entry.name_char   = byte_reg;
        result_next.entry.name_length = chars_next;
        result_next.entry.has_sum     = last_reg;
        result_next.entry.found       = complete_next;

        // end of packet: rearm
        if (in_valid_reg && last_reg)
        begin
            phase_next    = PH_HEAD;
            pos_next      = '0;
            skip_next     = '0;
            hold_next     = '0;
            ext_next      = '0;
            rem_next      = '0;
            chars_next    = '0;
            complete_next = 1'b0;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
    end

    // Config, state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_name_reg <= MAX_NAME_LENGTH_RST;
            max_ext_reg  <= MAX_EXTENSIONS_RST;
            phase_reg    <= PH_HEAD;
            pos_reg      <= '0;
            skip_reg     <= '0;
            hold_reg     <= '0;
            ext_reg      <= '0;
            rem_reg      <= '0;
            chars_reg    <= '0;
            complete_reg <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_MAX_NAME_LENGTH: max_name_reg <= cfg_data;
                    CFG_MAX_EXTENSIONS:  max_ext_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            skip_reg     <= skip_next;
            hold_reg     <= hold_next;
            ext_reg      <= ext_next;
            rem_reg      <= rem_next;
            chars_reg    <= chars_next;
            complete_reg <= complete_next;
            result_reg   <= result_next;
        end
    end

    assign in_flight = in_valid_reg || result_reg.push;
    assign result    = result_reg;

endmodule

// File: hw/rtl/tse_result_fifo.sv
module tse_result_fifo (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tse_pkg::tse_push_t           wr,
    input  logic                         pop,
    output tse_pkg::tse_entry_t          rd_data,
    output logic                         empty,
    output logic [tse_pkg::FIFO_CW-1:0]  count
);
    import tse_pkg::*;

    tse_entry_t         mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg;
    logic               do_pop;

    assign do_pop  = pop && (count_reg != '0);
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr.push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            if (wr.push && !do_pop)
            begin
                count_reg <= count_reg + FIFO_CW'(1);
            end
            else if (!wr.push && do_pop)
            begin
                count_reg <= count_reg - FIFO_CW'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            mem_reg[wr_ptr_reg] <= wr.entry;
        end
    end

endmodule

// File: hw/rtl/tse_out_ser.sv
module tse_out_ser (
    input  logic                        clk,
    input  logic                        rst_n,
    // queue side
    input  logic                        fifo_empty,
    input  tse_pkg::tse_entry_t         fifo_data,
    output logic                        fifo_pop,
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,
    output logic                        m_tuser
);
    import tse_pkg::*;

    logic       hold_valid_reg;
    tse_entry_t hold_reg;
    logic       char_pend_reg;
    logic       fire;
    logic       entry_done;
    logic       load;

    assign fire       = hold_valid_reg && m_tready;
    // a character with a summary behind it keeps the entry one more word
    assign entry_done = fire && !(char_pend_reg && hold_reg.has_sum);
    assign load       = !fifo_empty && (!hold_valid_reg || entry_done);
    assign fifo_pop   = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            char_pend_reg  <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                hold_valid_reg <= 1'b1;
                char_pend_reg  <= fifo_data.has_char;
            end
            else if (entry_done)
            begin
                hold_valid_reg <= 1'b0;
                char_pend_reg  <= 1'b0;
            end
            else if (fire)
            begin
                char_pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hold_reg <= fifo_data;
        end
    end

    // Word formatting: character, then summary
    always_comb
    begin
        m_tvalid = hold_valid_reg;
        if (char_pend_reg)
        begin
            m_tuser = 1'b0;
            m_tdata = {7'd0, 1'b0, hold_reg.name_length, hold_reg.name_char};
        end
        else
        begin
            m_tuser = 1'b1;
            m_tdata = {7'd0, hold_reg.found, hold_reg.name_length, NUL_BYTE};
        end
    end

endmodule

// File: hw/rtl/tls_sni_extractor_unit.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata = payload_byte, s_tlast = last_byte
// m_*       out  m_tvalid/m_tready  m_tdata = name_char, name_length, found;
//                                   m_tuser = kind
// cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One payload byte per cycle while s_tready is high; a byte is parsed in the cycle after
// it is taken, and its results then pass the result register, the result queue and the
// output holding register. A byte that ends the name and the packet gives two words;
// a four-entry result queue absorbs this.
// Input ready drops only while the queue plus bytes in flight could fill it.
// Reset restores both registers to their defaults and rearms the parser.
module tls_sni_extractor_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // payload stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] payload_byte
    input  logic                             s_tlast,
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [23:0]                      m_tdata,   // [7:0] name_char,
                                                        // [15:8] name_length,
                                                        // [16] found
    output logic                             m_tuser,   // [0] kind
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tse_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [7:0]                       cfg_data
);
    import tse_pkg::*;

    logic               in_accept;
    logic               in_flight;
    tse_push_t          result;
    tse_entry_t         fifo_data;
    logic               fifo_empty;
    logic               fifo_pop;
    logic [FIFO_CW-1:0] fifo_count;
    logic [FIFO_CW-1:0] occupancy;

    // Room for every word that bytes already taken may still add
    assign occupancy = fifo_count + FIFO_CW'(in_flight);
    assign s_tready  = (occupancy < FIFO_CW'(FIFO_DEPTH - 1));
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    tse_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_flight (in_flight),
        .result    (result)
    );

    tse_result_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (result),
        .pop     (fifo_pop),
        .rd_data (fifo_data),
        .empty   (fifo_empty),
        .count   (fifo_count)
    );

    tse_out_ser u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .fifo_data  (fifo_data),
        .fifo_pop   (fifo_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

// File: hw/rtl/tse_checker.sv
module tse_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tuser
);

    // stalled result word stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // summaries carry no character
    a_sum_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[7:0] == 8'd0)
        else $error("summary with nonzero character");

    // character words never report found and always count themselves
    a_char_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> !m_tdata[16] && m_tdata[15:8] != 8'd0)
        else $error("bad character word fields");

    // a found name is never empty
    a_found_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser && m_tdata[16] |-> m_tdata[15:8] != 8'd0)
        else $error("found with zero length");

endmodule

bind tls_sni_extractor_unit tse_checker u_tse_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: tb/sv/tls_sni_extractor_unit_tb.sv
module tls_sni_extractor_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tse_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_WAIT  = 8;
    localparam int HOLD_CYCLES  = 400;

    // One output word as seen on the result stream
    typedef struct {
        logic       kind;
        logic [7:0] name_char;
        logic [7:0] name_len;
        logic       found;
    } sni_word_t;

    // Parser states of the expected-result model
    typedef enum logic [3:0] {
        ST_HEAD, ST_SKIP_SID, ST_CS_HI, ST_CS_LO, ST_SKIP_CS, ST_CM_LEN, ST_SKIP_CM,
        ST_EXT_TYPE_HI, ST_EXT_TYPE_LO, ST_EXT_LEN_HI, ST_EXT_LEN_LO, ST_SKIP_EXT,
        ST_SNI_HDR, ST_NAME, ST_DONE, ST_FAIL
    } parse_st_t;

    // Shapes of generated packets
    typedef enum int {
        PK_GOOD, PK_NUL_END, PK_NUL_FIRST, PK_LEN_ZERO, PK_LEN_OVER,
        PK_NO_SNI, PK_TRUNC, PK_BAD_TYPE, PK_NOISE
    } hello_shape_t;
    localparam int PK_KINDS = 9;

    // Tracks the parser, queues the words each byte should produce, checks output
    class server_name_board;
        logic [7:0]  max_name_len;
        logic [7:0]  max_ext;
        parse_st_t   st;
        logic [15:0] pos;
        logic [15:0] skip;
        logic [7:0]  hi_hold;
        logic [7:0]  ext_seen;
        logic [7:0]  name_left;
        logic [7:0]  char_count;
        logic        name_done;
        sni_word_t   pending_words[$];
        int          errors;
        int          bytes_taken;

        function new();
            max_name_len = MAX_NAME_LENGTH_RST;
            max_ext      = MAX_EXTENSIONS_RST;
            errors       = 0;
            bytes_taken  = 0;
            rearm();
        endfunction

        function void rearm();
            st         = ST_HEAD;
            pos        = '0;
            skip       = '0;
            hi_hold    = '0;
            ext_seen   = '0;
            name_left  = '0;
            char_count = '0;
            name_done  = 1'b0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
            if (idx == CFG_MAX_NAME_LENGTH)
                max_name_len = val;
            else
                max_ext = val;
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

        function void start_skip(logic [15:0] n, parse_st_t skip_st, parse_st_t next_st);
            skip = n;
            st   = (n == 16'd0) ? next_st : skip_st;
        endfunction

        function void end_extension();
            ext_seen = ext_seen + 8'd1;
            st       = (ext_seen >= max_ext) ? ST_FAIL : ST_EXT_TYPE_HI;
        endfunction

        function void take_byte(logic [7:0] b, logic last);
            logic [15:0] w;
            sni_word_t   r;
            bytes_taken++;
            w = {hi_hold, b};
            case (st)
                ST_HEAD:
                begin
                    if (pos == POS_CONTENT_TYPE && b != CT_HANDSHAKE)
                        st = ST_FAIL;
                    else if (pos == POS_HS_TYPE && b != HS_CLIENT_HELLO)
                        st = ST_FAIL;
                    else if (pos == POS_SID_LEN)
                        start_skip({8'd0, b}, ST_SKIP_SID, ST_CS_HI);
                    if (pos != POS_MAX)
                        pos = pos + 16'd1;
                end
                ST_SKIP_SID, ST_SKIP_CS, ST_SKIP_CM, ST_SKIP_EXT:
                begin
                    skip = skip - 16'd1;
                    if (skip == 16'd0)
                    begin
                        case (st)
                            ST_SKIP_SID: st = ST_CS_HI;
                            ST_SKIP_CS:  st = ST_CM_LEN;
                            ST_SKIP_CM:  st = ST_EXT_TYPE_HI;
                            default:     end_extension();
                        endcase
                    end
                end
                ST_CS_HI:
                begin
                    hi_hold = b;
                    st      = ST_CS_LO;
                end
                ST_EXT_TYPE_HI:
                begin
                    hi_hold = b;
                    st      = ST_EXT_TYPE_LO;
                end
                ST_EXT_LEN_HI:
                begin
                    hi_hold = b;
                    st      = ST_EXT_LEN_LO;
                end
                ST_CS_LO:
                    start_skip(w, ST_SKIP_CS, ST_CM_LEN);
                // compression methods plus the extensions block length
                ST_CM_LEN:
                    start_skip({8'd0, b} + 16'd2, ST_SKIP_CM, ST_EXT_TYPE_HI);
                ST_EXT_TYPE_LO:
                begin
                    if (w == EXT_TYPE_SNI)
                    begin
                        skip = SNI_HDR_SKIP;
                        st   = ST_SNI_HDR;
                    end
                    else
                        st = ST_EXT_LEN_HI;
                end
                ST_EXT_LEN_LO:
                begin
                    skip = w;
                    if (w == 16'd0)
                        end_extension();
                    else
                        st = ST_SKIP_EXT;
                end
                ST_SNI_HDR:
                begin
                    if (skip == SNI_LEN_HI)
                        hi_hold = b;
                    else if (skip == SNI_LEN_LO)
                    begin
                        if (w == 16'd0 || w > {8'd0, max_name_len})
                            st = ST_FAIL;
                        else
                        begin
                            name_left = w[7:0];
                            st        = ST_NAME;
                        end
                    end
                    skip = skip - 16'd1;
                end
                ST_NAME:
                begin
                    if (b == NUL_BYTE)
                    begin
                        if (char_count != 8'd0)
                        begin
                            name_done = 1'b1;
                            st        = ST_DONE;
                        end
                        else
                            st = ST_FAIL;
                    end
                    else
                    begin
                        char_count  = char_count + 8'd1;
                        name_left   = name_left - 8'd1;
                        r.kind      = 1'b0;
                        r.name_char = b;
                        r.name_len  = char_count;
                        r.found     = 1'b0;
                        pending_words.push_back(r);
                        if (name_left == 8'd0)
                        begin
                            name_done = 1'b1;
                            st        = ST_DONE;
                        end
                    end
                end
                default: ;
            endcase

            // end of packet: summary word, then start over
            if (last)
            begin
                r.kind      = 1'b1;
                r.name_char = 8'd0;
                r.name_len  = char_count;
                r.found     = name_done;
                pending_words.push_back(r);
                rearm();
            end
        endfunction

        function void compare_field(string what, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
                errors++;
            end
        endfunction

        function void check_word(logic kind, logic [7:0] name_char, logic [7:0] name_len,
                                 logic found);
            sni_word_t w;
            if (pending_words.size() == 0)
            begin
                $display("%0t: extra word, expected none, got kind %0d char %0d",
                         $time, kind, name_char);
                $display("%0t: extra word len %0d found %0d", $time, name_len, found);
                errors++;
                return;
            end
            w = pending_words.pop_front();
            compare_field("kind", {7'd0, w.kind}, {7'd0, kind});
            compare_field("name_char", w.name_char, name_char);
            compare_field("name_length", w.name_len, name_len);
            compare_field("found", {7'd0, w.found}, {7'd0, found});
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [23:0]            m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]             cfg_data;

    server_name_board board = new();
    int               idle_pct = 25;
    int               cycles = 0;
    bit               hold_go = 1'b0;
    logic [7:0]       pkt_q[$];

    tls_sni_extractor_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Accepted words on both streams
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            board.take_byte(s_tdata, s_tlast);
        if (rst_n && m_tvalid && m_tready)
            board.check_word(m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[16]);
    end

    // Result sink: random stalls plus one long hold while input keeps coming
    initial
    begin
        int stall_left;
        bit stalled_once;
        stall_left   = 0;
        stalled_once = 1'b0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!stalled_once && hold_go)
            begin
                stalled_once = 1'b1;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic send_word(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_packet();
        foreach (pkt_q[i])
            send_word(pkt_q[i], i == pkt_q.size() - 1);
    endtask

    // Stop input and wait until every expected word is out, plus pipeline slack
    task automatic settle_block();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        board.set_reg(idx, val);
    endtask

    function automatic void put_rand(int n);
        repeat (n) pkt_q.push_back(8'($urandom));
    endfunction

    function automatic void put16(logic [15:0] v);
        pkt_q.push_back(v[15:8]);
        pkt_q.push_back(v[7:0]);
    endfunction

    function automatic int max_name_cap();
        return int'(board.max_name_len);
    endfunction

    function automatic hello_shape_t pick_shape();
        int r;
        r = $urandom_range(99);
        if (r < 35) return PK_GOOD;
        if (r < 50) return PK_NUL_END;
        if (r < 57) return PK_NUL_FIRST;
        if (r < 63) return PK_LEN_ZERO;
        if (r < 70) return PK_LEN_OVER;
        if (r < 78) return PK_NO_SNI;
        if (r < 90) return PK_TRUNC;
        if (r < 95) return PK_BAD_TYPE;
        return PK_NOISE;
    endfunction

    // Build one ClientHello-like packet of the given shape into pkt_q
    function automatic void build_packet(hello_shape_t k);
        int          n_other;
        int          name_len;
        int          cap;
        int          cut;
        int          bad_at;
        int          nul_at;
        int          sid_len;
        int          cs_len;
        int          cm_len;
        logic [15:0] ext_type;
        logic [7:0]  b;
        pkt_q.delete();
        if (k == PK_NOISE)
        begin
            put_rand($urandom_range(1, 40));
            return;
        end

        // record header and handshake header up to the session id length
        put_rand(43);
        pkt_q[0] = CT_HANDSHAKE;
        pkt_q[5] = HS_CLIENT_HELLO;
        bad_at = 0;
        if (k == PK_BAD_TYPE)
        begin
            bad_at = $urandom_range(1) ? 5 : 0;
            do b = 8'($urandom);
            while (b == ((bad_at == 0) ? CT_HANDSHAKE : HS_CLIENT_HELLO));
            pkt_q[bad_at] = b;
        end

        sid_len = ($urandom_range(7) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
        pkt_q.push_back(8'(sid_len));
        put_rand(sid_len);
        cs_len = ($urandom_range(15) == 0) ? $urandom_range(256, 270) : $urandom_range(0, 4);
        put16(16'(cs_len));
        put_rand(cs_len);
        cm_len = $urandom_range(0, 3);
        pkt_q.push_back(8'(cm_len));
        put_rand(cm_len + 2);

        // extensions ahead of the server name
        n_other = (k == PK_NO_SNI) ? $urandom_range(1, 6) : $urandom_range(0, 3);
        repeat (n_other)
        begin
            do ext_type = 16'($urandom);
            while (ext_type == EXT_TYPE_SNI);
            put16(ext_type);
            b = ($urandom_range(5) == 0) ? 8'd0 : 8'($urandom_range(1, 5));
            put16({8'd0, b});
            put_rand(b);
        end

        if (k != PK_NO_SNI)
        begin
            put16(EXT_TYPE_SNI);
            put_rand(5);   // ext len, list len, name type
            cap = (max_name_cap() < 12) ? max_name_cap() : 12;
            if (k == PK_LEN_ZERO)
                name_len = 0;
            else if (k == PK_LEN_OVER)
            begin
                if (max_name_cap() == 255 || $urandom_range(3) == 0)
                    name_len = $urandom_range(256, 65535);
                else
                    name_len = $urandom_range(max_name_cap() + 1, 255);
            end
            else if (cap == 0)
                name_len = 1;
            else if ($urandom_range(9) == 0)
                name_len = max_name_cap();
            else
                name_len = $urandom_range(1, cap);
            put16(16'(name_len));
            nul_at = -1;
            if (k == PK_NUL_FIRST)
                nul_at = 0;
            else if (k == PK_NUL_END && name_len > 0)
                nul_at = $urandom_range(1, name_len);
            for (int i = 0; i < ((name_len > 255) ? 8 : name_len + 1); i++)
                pkt_q.push_back((i == nul_at) ? NUL_BYTE : 8'($urandom_range(1, 255)));
        end
        put_rand($urandom_range(0, 4));

        if (k == PK_TRUNC)
        begin
            cut   = $urandom_range(1, pkt_q.size());
            pkt_q = pkt_q[0:cut-1];
        end
        else if (k == PK_BAD_TYPE)
        begin
            cut   = $urandom_range(bad_at + 1, pkt_q.size());
            pkt_q = pkt_q[0:cut-1];
        end
    endfunction

    // Stimulus and verdict
    initial
    begin
        logic [7:0] name_caps [4];
        logic [7:0] ext_caps [4];
        logic [7:0] name_cap;
        logic [7:0] ext_cap;
        int         start;
        name_caps = '{8'd255, 8'd1, 8'd0, 8'd7};
        ext_caps  = '{8'd255, 8'd1, 8'd0, 8'd3};
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'd0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_MAX_NAME_LENGTH;
        cfg_data  <= 8'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: short failing records, then every packet shape once
        send_word(~CT_HANDSHAKE, 1'b1);
        send_word(CT_HANDSHAKE, 1'b1);
        send_word(8'd0, 1'b1);
        send_word(CT_HANDSHAKE, 1'b0);
        repeat (4) send_word(8'hFF, 1'b0);
        send_word(8'hFE, 1'b1);
        for (int k = 0; k < PK_KINDS; k++)
        begin
            build_packet(hello_shape_t'(k));
            send_packet();
        end

        // random packets under several register settings
        for (int ph = 0; ph < 5; ph++)
        begin
            settle_block();
            name_cap = (ph == 4) ? 8'($urandom_range(1, 255)) : name_caps[ph];
            ext_cap  = (ph == 4) ? 8'($urandom_range(1, 255)) : ext_caps[ph];
            write_reg(CFG_MAX_NAME_LENGTH, name_cap);
            write_reg(CFG_MAX_EXTENSIONS, ext_cap);
            cfg_valid <= 1'b0;
            idle_pct = (ph == 1) ? 0 : 25;
            // long receiver hold while packets keep coming
            if (ph == 4)
                hold_go = 1'b1;
            start = board.bytes_taken;
            while (board.bytes_taken - start < ((ph == 4) ? 300 : 140))
            begin
                build_packet(pick_shape());
                send_packet();
            end
        end
        settle_block();

        if (board.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
